// File: src/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and constants for the reconnect backoff controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

   // event kinds carried on req_tuser
   localparam logic [1:0] FUNC_TICK      = 2'd0;
   localparam logic [1:0] FUNC_CONNECTED = 2'd1;
   localparam logic [1:0] FUNC_LOST      = 2'd2;

   // link states
   localparam logic [1:0] LINK_IDLE      = 2'd0;
   localparam logic [1:0] LINK_CONNECTED = 2'd1;
   localparam logic [1:0] LINK_DISABLED  = 2'd2;
   localparam logic [1:0] LINK_WAITING   = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE          = 2'd0;
   localparam logic [1:0] ERR_NO_NEGOTIATOR = 2'd1;
   localparam logic [1:0] ERR_NEGOTIATION   = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_START_DELAY   = 2'd0;
   localparam logic [1:0] CSR_DELAY_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_GROWTH_FACTOR = 2'd2;
   localparam logic [1:0] CSR_NEGOTIATOR    = 2'd3;

   // configuration reset values
   localparam logic [31:0] START_DELAY_RST   = 32'd1000;
   localparam logic [31:0] DELAY_LIMIT_RST   = 32'd60000;
   localparam logic [15:0] GROWTH_FACTOR_RST = 16'd512;

   // Q8.8 one
   localparam logic [15:0] FACTOR_ONE = 16'd256;

   localparam int TIME_W   = 48;
   localparam int DELAY_W  = 32;
   localparam int COUNT_W  = 16;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 104;

   typedef struct packed {
      logic [31:0] start_delay;
      logic [31:0] delay_limit;
      logic [15:0] growth_factor;
      logic        negotiator_present;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [TIME_W-1:0] now;
      logic              user_initiated;
      logic              negotiate_ok;
   } evt_type;

   typedef struct packed {
      logic [1:0]         link_mode;
      logic [COUNT_W-1:0] failures;
      logic [DELAY_W-1:0] backoff_delay;
      logic [TIME_W-1:0]  retry_at;
      logic               retry_valid;
      logic [1:0]         last_error;
   } state_type;

   typedef struct packed {
      logic attempted;
      logic reconnected;
   } flags_type;

endpackage

`default_nettype wire

// File: src/rbc_step.sv
// ----------------------------------------------------------------------------
// rbc_step
// Next-state logic for one event: attempt check, rescheduling, delay growth and reset on connect.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_step (
   input  wire rbc_pkg::cfg_type   cfg,
   input  wire rbc_pkg::evt_type   evt,
   input  wire rbc_pkg::state_type st,
   output rbc_pkg::state_type      st_nxt,
   output rbc_pkg::flags_type      flags
);

   logic [15:0] factor;
   logic [31:0] cap;
   logic [47:0] product;
   logic [39:0] grown;
   logic [31:0] grown_delay;
   logic [48:0] retry_sum;
   logic [47:0] retry_sat;
   logic        due;

   always_comb begin
      factor  = (cfg.growth_factor < rbc_pkg::FACTOR_ONE) ? rbc_pkg::FACTOR_ONE
                                                          : cfg.growth_factor;
      cap     = (cfg.delay_limit > cfg.start_delay) ? cfg.delay_limit : cfg.start_delay;
      product = {16'd0, st.backoff_delay} * {32'd0, factor};
      grown   = product[47:8];
      grown_delay = (grown < {8'd0, cap}) ? grown[31:0] : cap;

      // saturate the retry time at the top of the 48-bit range
      retry_sum = {1'b0, evt.now} + {17'd0, st.backoff_delay};
      retry_sat = retry_sum[48] ? {48{1'b1}} : retry_sum[47:0];

      due = (st.link_mode == rbc_pkg::LINK_WAITING) && st.retry_valid &&
            (evt.now >= st.retry_at);
   end

   always_comb begin
      st_nxt            = st;
      flags.attempted   = 1'b0;
      flags.reconnected = 1'b0;
      case (evt.func)
         rbc_pkg::FUNC_TICK: begin
            if (due) begin
               flags.attempted = 1'b1;
               if (cfg.negotiator_present && evt.negotiate_ok) begin
                  flags.reconnected    = 1'b1;
                  st_nxt.link_mode     = rbc_pkg::LINK_CONNECTED;
                  st_nxt.failures      = '0;
                  st_nxt.backoff_delay = cfg.start_delay;
                  st_nxt.retry_valid   = 1'b0;
                  st_nxt.retry_at      = '0;
                  st_nxt.last_error    = rbc_pkg::ERR_NONE;
               end else begin
                  st_nxt.link_mode  = rbc_pkg::LINK_WAITING;
                  st_nxt.last_error = cfg.negotiator_present ? rbc_pkg::ERR_NEGOTIATION
                                                             : rbc_pkg::ERR_NO_NEGOTIATOR;
                  if (st.failures != {16{1'b1}}) begin
                     st_nxt.failures = st.failures + 16'd1;
                  end
                  st_nxt.retry_at      = retry_sat;
                  st_nxt.retry_valid   = 1'b1;
                  st_nxt.backoff_delay = grown_delay;
               end
            end
         end
         rbc_pkg::FUNC_CONNECTED: begin
            st_nxt.link_mode     = rbc_pkg::LINK_CONNECTED;
            st_nxt.failures      = '0;
            st_nxt.backoff_delay = cfg.start_delay;
            st_nxt.retry_valid   = 1'b0;
            st_nxt.retry_at      = '0;
            st_nxt.last_error    = rbc_pkg::ERR_NONE;
         end
         rbc_pkg::FUNC_LOST: begin
            if (evt.user_initiated) begin
               st_nxt.link_mode   = rbc_pkg::LINK_DISABLED;
               st_nxt.retry_valid = 1'b0;
               st_nxt.retry_at    = '0;
            end else begin
               st_nxt.link_mode   = rbc_pkg::LINK_WAITING;
               st_nxt.retry_at    = retry_sat;
               st_nxt.retry_valid = 1'b1;
            end
         end
         default: begin
            st_nxt = st;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/reconnect_backoff_controller.sv
// ----------------------------------------------------------------------------
// reconnect_backoff_controller
// Paces reconnect attempts of a link with a capped exponential backoff.
// ----------------------------------------------------------------------------
// Path: a request beat taken is held in the input register and moves into the result
//   register once that is free. Throughput: one event per cycle while the result
//   channel does not stall; the state update, the 32x16 delay multiply and the 48-bit
//   retry add all sit between the input and result registers.
// Reset: synchronous, active high; clears both valid flags, loads the config and state
//   registers with their reset values and puts the link idle with the start delay.
`default_nettype none

module reconnect_backoff_controller (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [rbc_pkg::REQ_TDATA_W-1:0] req_tdata,
                                    // now[47:0], user_initiated[48], negotiate_ok[49], zero
   input  wire  [1:0]  req_tuser,   // func[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [rbc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
                                    // attempted[0], reconnected[1], retry_pending[2],
                                    // retry_time[50:3], error_code[52:51],
                                    // link_state[54:53], failure_count[70:55],
                                    // delay_now[102:71], zero[103]
   // configuration
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   rbc_pkg::cfg_type   cfg_ff, cfg_in;
   rbc_pkg::evt_type   evt_ff, evt_in;
   rbc_pkg::state_type st_ff, st_in;
   rbc_pkg::state_type st_nxt;
   rbc_pkg::flags_type flags;
   logic               evt_valid_ff, evt_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [rbc_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               advance;
   logic               req_take;

   // Advance the held event into the result register once that is free.
   assign advance    = evt_valid_ff && (!rsp_valid_ff || rsp_tready);
   // The input register refills while a finished result still waits.
   assign req_tready = !evt_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   rbc_step u_step (
      .cfg    (cfg_ff),
      .evt    (evt_ff),
      .st     (st_ff),
      .st_nxt (st_nxt),
      .flags  (flags)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rbc_pkg::CSR_START_DELAY:   cfg_in.start_delay        = csr_wdata;
            rbc_pkg::CSR_DELAY_LIMIT:   cfg_in.delay_limit        = csr_wdata;
            rbc_pkg::CSR_GROWTH_FACTOR: cfg_in.growth_factor      = csr_wdata[15:0];
            rbc_pkg::CSR_NEGOTIATOR:    cfg_in.negotiator_present = csr_wdata[0];
            default:                    cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_comb begin
      evt_in       = evt_ff;
      evt_valid_in = evt_valid_ff;
      if (req_take) begin
         evt_in.func           = req_tuser;
         evt_in.now            = req_tdata[47:0];
         evt_in.user_initiated = req_tdata[48];
         evt_in.negotiate_ok   = req_tdata[49];
         evt_valid_in          = 1'b1;
      end else if (advance) begin
         evt_valid_in = 1'b0;
      end
   end

   always_comb begin
      st_in        = st_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         // commit the state and capture the status after this event
         st_in        = st_nxt;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0,
                         st_nxt.backoff_delay,
                         st_nxt.failures,
                         st_nxt.link_mode,
                         st_nxt.last_error,
                         st_nxt.retry_valid ? st_nxt.retry_at : 48'd0,
                         st_nxt.retry_valid,
                         flags.reconnected,
                         flags.attempted};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay        <= rbc_pkg::START_DELAY_RST;
         cfg_ff.delay_limit        <= rbc_pkg::DELAY_LIMIT_RST;
         cfg_ff.growth_factor      <= rbc_pkg::GROWTH_FACTOR_RST;
         cfg_ff.negotiator_present <= 1'b0;
         st_ff.link_mode           <= rbc_pkg::LINK_IDLE;
         st_ff.failures            <= '0;
         st_ff.backoff_delay       <= rbc_pkg::START_DELAY_RST;
         st_ff.retry_at            <= '0;
         st_ff.retry_valid         <= 1'b0;
         st_ff.last_error          <= rbc_pkg::ERR_NONE;
         evt_valid_ff              <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         st_ff        <= st_in;
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      evt_ff      <= evt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
